>>> hdl/rse_pkg.sv
package rse_pkg;

  localparam int unsigned WORD_W          = 32;
  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned CFG_ADDR_W      = 3;
  localparam int unsigned CFG_DATA_W      = 32;

  localparam logic [2:0] KIND_PUSH_IMM = 3'd0;
  localparam logic [2:0] KIND_PUSH_X   = 3'd1;
  localparam logic [2:0] KIND_ADD      = 3'd2;
  localparam logic [2:0] KIND_SUB      = 3'd3;
  localparam logic [2:0] KIND_MUL      = 3'd4;
  localparam logic [2:0] KIND_DIV      = 3'd5;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_DIVZ  = 3'd3;
  localparam logic [2:0] ST_DEPTH = 3'd4;

  localparam logic REG_X_VALUE = 1'b0;

  typedef struct packed {
    logic [2:0]  kind;
    logic [30:0] immediate;
    logic        last;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic [2:0]               status;
  } out_t;

endpackage

>>> hdl/rpn_stack_evaluator.sv
// Postfix program evaluator on a stack of signed 32-bit words.
// Each transfer on the in_ channel is one instruction: push immediate, push
// the x_value register, add, sub, mul or div. The item flagged last closes the
// program, and one transfer on the out_ channel then carries the sole stack
// word with status ok, or value zero with the first error or a depth error.
// x_value is written through the cfg_ port; the user must write it only while
// the block is idle, as the block itself does not enforce this. Add and sub
// first read the word below the top from the stack memory and then pass
// through the shared adder. Mul and div iterate one bit a cycle on the same
// adder. A last item then passes through S_FIN to load the output register.
// in_stall is high whenever the block is not idle.
// A result waits in the output register while out_stall is high; a following
// item that ends a program then waits until that register is free.
// Reset clears the stack depth, the error, the output valid and x_value.
module rpn_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rse_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rse_pkg::out_t                   out_data,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [rse_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [rse_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [rse_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  localparam int unsigned W   = rse_pkg::WORD_W;
  localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned DW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CW  = $clog2(W);
  localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);
  localparam logic [DW-1:0] ONE  = DW'(1);
  localparam logic [DW-1:0] TWO  = DW'(2);
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OP   = 3'd1;
  localparam logic [2:0] S_DABS = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DNEG = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [2:0]    err_r, err_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [W-1:0]  tos_r, tos_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  opa_r, opa_nxt;
  logic [W-1:0]  opb_r, opb_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt;
  logic [2:0]    kind_r, kind_nxt;
  logic          last_r, last_nxt;
  logic [W-1:0]  x_value_r, x_value_nxt;
  logic          out_valid_r, out_valid_nxt;
  rse_pkg::out_t out_data_r, out_data_nxt;

  logic [W-1:0]  stack_mem [STACK_DEPTH];
  logic [W-1:0]  rd_data_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] depth_m1;
  logic [DW-1:0] depth_m2;
  logic          mem_we;

  logic [W-1:0]  add_a;
  logic [W-1:0]  add_b;
  logic          add_sub;
  logic [W:0]    sum;
  logic [W-1:0]  rem_sh;
  logic [W-1:0]  push_word;
  logic [2:0]    done_state;
  logic [2:0]    after_in;
  logic          cfg_wr;

  assign depth_m1   = depth_r - ONE;
  assign depth_m2   = depth_r - TWO;
  assign wr_addr    = depth_m1[AW-1:0];
  assign rd_addr    = depth_m2[AW-1:0];
  assign rem_sh     = {acc_r[W-2:0], opa_r[W-1]};
  assign push_word  = (in_data.kind == rse_pkg::KIND_PUSH_IMM) ?
                      {1'b0, in_data.immediate} : x_value_r;
  assign done_state = last_r ? S_FIN : S_IDLE;
  assign after_in   = in_data.last ? S_FIN : S_IDLE;

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == rse_pkg::REG_X_VALUE);
  assign cfg_prdata = (cfg_paddr[2] == rse_pkg::REG_X_VALUE) ? x_value_r : '0;
  assign x_value_nxt = cfg_wr ? cfg_pwdata : x_value_r;

  always_comb begin
    add_a   = acc_r;
    add_b   = opb_r;
    add_sub = 1'b0;
    case (state_r)
      S_OP: begin
        if (kind_r == rse_pkg::KIND_DIV) begin
          add_a   = '0;
          add_b   = rd_data_r;
          add_sub = 1'b1;
        end else begin
          add_a   = rd_data_r;
          add_b   = tos_r;
          add_sub = (kind_r == rse_pkg::KIND_SUB);
        end
      end
      S_DABS: begin
        add_a   = '0;
        add_b   = tos_r;
        add_sub = 1'b1;
      end
      S_MUL: begin
        add_a = acc_r;
        add_b = opb_r[0] ? opa_r : '0;
      end
      S_DIV: begin
        add_a   = rem_sh;
        add_b   = opb_r;
        add_sub = 1'b1;
      end
      S_DNEG: begin
        add_a   = '0;
        add_b   = opa_r;
        add_sub = 1'b1;
      end
      default: begin
        add_a   = acc_r;
        add_b   = opb_r;
        add_sub = 1'b0;
      end
    endcase
  end

  assign sum = {1'b0, add_a} + {1'b0, add_b ^ {W{add_sub}}} + {{W{1'b0}}, add_sub};

  always_comb begin
    state_nxt     = state_r;
    err_nxt       = err_r;
    depth_nxt     = depth_r;
    tos_nxt       = tos_r;
    acc_nxt       = acc_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    kind_nxt      = kind_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_data.kind;
          last_nxt = in_data.last;
          state_nxt = after_in;
          if (err_r == rse_pkg::ST_OK) begin
            case (in_data.kind) inside
              rse_pkg::KIND_PUSH_IMM, rse_pkg::KIND_PUSH_X: begin
                if (depth_r == FULL) begin
                  err_nxt = rse_pkg::ST_OVER;
                end else begin
                  mem_we    = (depth_r != '0);
                  tos_nxt   = push_word;
                  depth_nxt = depth_r + ONE;
                end
              end
              rse_pkg::KIND_ADD, rse_pkg::KIND_SUB,
              rse_pkg::KIND_MUL, rse_pkg::KIND_DIV: begin
                if (depth_r < TWO) begin
                  err_nxt = rse_pkg::ST_UNDER;
                end else begin
                  state_nxt = S_OP;
                end
              end
              default: begin
                state_nxt = after_in;
              end
            endcase
          end
        end
      end
      S_OP: begin
        case (kind_r)
          rse_pkg::KIND_MUL: begin
            acc_nxt   = '0;
            opa_nxt   = rd_data_r;
            opb_nxt   = tos_r;
            cnt_nxt   = '0;
            state_nxt = S_MUL;
          end
          rse_pkg::KIND_DIV: begin
            if (tos_r == '0) begin
              err_nxt   = rse_pkg::ST_DIVZ;
              state_nxt = done_state;
            end else begin
              opa_nxt   = rd_data_r[W-1] ? sum[W-1:0] : rd_data_r;
              neg_nxt   = rd_data_r[W-1] ^ tos_r[W-1];
              state_nxt = S_DABS;
            end
          end
          default: begin
            tos_nxt   = sum[W-1:0];
            depth_nxt = depth_m1;
            state_nxt = done_state;
          end
        endcase
      end
      S_DABS: begin
        opb_nxt   = tos_r[W-1] ? sum[W-1:0] : tos_r;
        acc_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_MUL: begin
        acc_nxt = sum[W-1:0];
        opa_nxt = {opa_r[W-2:0], 1'b0};
        opb_nxt = {1'b0, opb_r[W-1:1]};
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CNT_LAST) begin
          tos_nxt   = sum[W-1:0];
          depth_nxt = depth_m1;
          state_nxt = done_state;
        end
      end
      S_DIV: begin
        if (sum[W]) begin
          acc_nxt = sum[W-1:0];
          opa_nxt = {opa_r[W-2:0], 1'b1};
        end else begin
          acc_nxt = rem_sh;
          opa_nxt = {opa_r[W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_DNEG;
        end
      end
      S_DNEG: begin
        tos_nxt   = neg_r ? sum[W-1:0] : opa_r;
        depth_nxt = depth_m1;
        state_nxt = done_state;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (err_r != rse_pkg::ST_OK) begin
            out_data_nxt.value  = '0;
            out_data_nxt.status = err_r;
          end else if (depth_r != ONE) begin
            out_data_nxt.value  = '0;
            out_data_nxt.status = rse_pkg::ST_DEPTH;
          end else begin
            out_data_nxt.value  = tos_r;
            out_data_nxt.status = rse_pkg::ST_OK;
          end
          depth_nxt = '0;
          err_nxt   = rse_pkg::ST_OK;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[wr_addr] <= tos_r;
    end
    rd_data_r <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      err_r       <= rse_pkg::ST_OK;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
      x_value_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      err_r       <= err_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
      x_value_r   <= x_value_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r      <= tos_nxt;
    acc_r      <= acc_nxt;
    opa_r      <= opa_nxt;
    opb_r      <= opb_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    kind_r     <= kind_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> hdl/rse_checker.sv
module rse_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input rse_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input rse_pkg::out_t out_data
);

  // A stalled result keeps its contents until the transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // After the item that closes a program is taken, the block is always still busy and stalls its input.
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last |=> in_stall)
    else $error("block ready straight after a closing item");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == rse_pkg::ST_OK ||
                   out_data.status == rse_pkg::ST_UNDER ||
                   out_data.status == rse_pkg::ST_OVER ||
                   out_data.status == rse_pkg::ST_DIVZ ||
                   out_data.status == rse_pkg::ST_DEPTH))
    else $error("status code out of range");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != rse_pkg::ST_OK) |-> (out_data.value == '0))
    else $error("non-zero value with an error status");

endmodule

bind rpn_stack_evaluator rse_checker u_rse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned STACK_WORDS  = rse_pkg::STACK_DEPTH_DEF;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 128;

  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;

  localparam logic [rse_pkg::CFG_ADDR_W-1:0] X_ADDR = {rse_pkg::REG_X_VALUE, 2'b00};

  class rpn_shadow_eval;
    logic [rse_pkg::WORD_W-1:0] words [STACK_WORDS];
    int unsigned                depth;
    logic [2:0]                 err;
    logic [rse_pkg::WORD_W-1:0] x_reg;
    rse_pkg::out_t              answers [$];
    int unsigned                fails;

    function new();
      depth = 0;
      err   = rse_pkg::ST_OK;
      x_reg = '0;
      fails = 0;
    endfunction

    task report_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      fails++;
    endtask

    function void set_x(input logic [rse_pkg::WORD_W-1:0] v);
      x_reg = v;
    endfunction

    function logic [rse_pkg::WORD_W-1:0] trunc_div(input logic [rse_pkg::WORD_W-1:0] a,
                                                   input logic [rse_pkg::WORD_W-1:0] b);
      logic [rse_pkg::WORD_W-1:0] ma;
      logic [rse_pkg::WORD_W-1:0] mb;
      logic [rse_pkg::WORD_W-1:0] q;
      ma = a[rse_pkg::WORD_W-1] ? -a : a;
      mb = b[rse_pkg::WORD_W-1] ? -b : b;
      q  = ma / mb;
      return (a[rse_pkg::WORD_W-1] ^ b[rse_pkg::WORD_W-1]) ? -q : q;
    endfunction

    function void push_word(input logic [rse_pkg::WORD_W-1:0] w);
      if (depth >= STACK_WORDS) begin
        err = rse_pkg::ST_OVER;
        return;
      end
      words[depth] = w;
      depth++;
    endfunction

    function void apply_op(input logic [2:0] k);
      logic [rse_pkg::WORD_W-1:0] lhs;
      logic [rse_pkg::WORD_W-1:0] rhs;
      logic [rse_pkg::WORD_W-1:0] r;
      if (depth < 2) begin
        err = rse_pkg::ST_UNDER;
        return;
      end
      rhs = words[depth-1];
      lhs = words[depth-2];
      case (k)
        rse_pkg::KIND_ADD: r = lhs + rhs;
        rse_pkg::KIND_SUB: r = lhs - rhs;
        rse_pkg::KIND_MUL: r = lhs * rhs;
        default: begin
          if (rhs == '0) begin
            err = rse_pkg::ST_DIVZ;
            return;
          end
          r = trunc_div(lhs, rhs);
        end
      endcase
      words[depth-2] = r;
      depth--;
    endfunction

    function void note_instruction(input rse_pkg::in_t it);
      rse_pkg::out_t r;
      if (err == rse_pkg::ST_OK) begin
        case (it.kind)
          rse_pkg::KIND_PUSH_IMM: push_word({1'b0, it.immediate});
          rse_pkg::KIND_PUSH_X:   push_word(x_reg);
          rse_pkg::KIND_ADD, rse_pkg::KIND_SUB,
          rse_pkg::KIND_MUL, rse_pkg::KIND_DIV: apply_op(it.kind);
          default: ;
        endcase
      end
      if (it.last) begin
        r.value = '0;
        if (err != rse_pkg::ST_OK) begin
          r.status = err;
        end else if (depth != 1) begin
          r.status = rse_pkg::ST_DEPTH;
        end else begin
          r.status = rse_pkg::ST_OK;
          r.value  = words[0];
        end
        answers.insert(answers.size(), r);
        depth = 0;
        err   = rse_pkg::ST_OK;
      end
    endfunction

    task check_answer(input rse_pkg::out_t got);
      rse_pkg::out_t want;
      if (answers.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %h status %0d",
                                  got.value, got.status));
        return;
      end
      want = answers.pop_front();
      if (got.value !== want.value)
        report_mismatch($sformatf("value %h, expected %h", got.value, want.value));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
    endtask

    function int unsigned pending();
      return answers.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n       = 1'b0;
  logic                           in_valid    = 1'b0;
  logic                           in_stall;
  rse_pkg::in_t                   in_data     = '0;
  logic                           out_valid;
  logic                           out_stall   = 1'b0;
  rse_pkg::out_t                  out_data;
  logic                           cfg_psel    = 1'b0;
  logic                           cfg_penable = 1'b0;
  logic                           cfg_pwrite  = 1'b0;
  logic [rse_pkg::CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [rse_pkg::CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [rse_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  rpn_shadow_eval shadow = new();
  bit             idle_on = 1'b1;
  logic           hold_req = 1'b0;
  int unsigned    items_sent = 0;
  int unsigned    quiet_cycles = 0;

  rpn_stack_evaluator #(
    .STACK_DEPTH(STACK_WORDS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) shadow.note_instruction(in_data);
      if (out_valid && !out_stall) shadow.check_answer(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // The receiver stalls at random while idle_on is set or, on request, holds off once for a long stretch.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < 26);
      end
    end
  end

  function automatic rse_pkg::in_t make_item(input logic [2:0] k, input logic [30:0] imm,
                                             input logic lst);
    rse_pkg::in_t it;
    it.kind      = k;
    it.immediate = imm;
    it.last      = lst;
    return it;
  endfunction

  function automatic logic [30:0] rand_imm();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0:       return '0;
      1:       return 31'h7FFF_FFFF;
      2, 3, 4: return 31'($urandom_range(20));
      5:       return 31'($urandom_range(1000));
      default: return r[30:0];
    endcase
  endfunction

  function automatic logic [2:0] rand_op();
    case ($urandom_range(3))
      0:       return rse_pkg::KIND_ADD;
      1:       return rse_pkg::KIND_SUB;
      2:       return rse_pkg::KIND_MUL;
      default: return rse_pkg::KIND_DIV;
    endcase
  endfunction

  task automatic send_item(input rse_pkg::in_t it);
    while (idle_on && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic write_x(input logic [rse_pkg::CFG_DATA_W-1:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= X_ADDR;
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    shadow.set_x(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== v)
      shadow.report_mismatch($sformatf("x_value reads %h, expected %h", cfg_prdata, v));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shadow.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_wellformed();
    int       pushes_left;
    int       d;
    logic [2:0] k;
    pushes_left = $urandom_range(1, 7);
    d = 0;
    while (pushes_left > 0 || d > 1) begin
      if (d >= 2 && (pushes_left == 0 || $urandom_range(1) == 1)) begin
        k = rand_op();
        d--;
      end else begin
        k = $urandom_range(1) ? rse_pkg::KIND_PUSH_X : rse_pkg::KIND_PUSH_IMM;
        pushes_left--;
        d++;
      end
      send_item(make_item(k, rand_imm(), (pushes_left == 0) && (d == 1)));
    end
  endtask

  task automatic run_deep();
    int n;
    n = $urandom_range(STACK_WORDS - 3, STACK_WORDS + 2);
    for (int i = 0; i < n; i++)
      send_item(make_item($urandom_range(1) ? rse_pkg::KIND_PUSH_X : rse_pkg::KIND_PUSH_IMM,
                          rand_imm(), 1'b0));
    for (int i = 1; i < n; i++)
      send_item(make_item(rand_op(), rand_imm(), i == n - 1));
  endtask

  task automatic run_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++)
      send_item(make_item(3'($urandom_range(7)), rand_imm(),
                          (i == n - 1) || ($urandom_range(9) == 0)));
  endtask

  initial begin
    logic [rse_pkg::CFG_DATA_W-1:0] xv;
    int unsigned                    budget;
    int unsigned                    sel;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_x(32'h8000_0000);
    send_item(make_item(rse_pkg::KIND_PUSH_IMM, 31'h7FFF_FFFF, 1'b0));
    send_item(make_item(rse_pkg::KIND_PUSH_IMM, 31'd1, 1'b0));
    send_item(make_item(rse_pkg::KIND_ADD, 31'd0, 1'b1));
    send_item(make_item(rse_pkg::KIND_PUSH_X, 31'h7FFF_FFFF, 1'b0));
    send_item(make_item(rse_pkg::KIND_PUSH_IMM, 31'd0, 1'b0));
    send_item(make_item(rse_pkg::KIND_PUSH_IMM, 31'd1, 1'b0));
    send_item(make_item(rse_pkg::KIND_SUB, 31'd0, 1'b0));
    send_item(make_item(rse_pkg::KIND_DIV, 31'd0, 1'b1));
    send_item(make_item(rse_pkg::KIND_PUSH_IMM, 31'd5, 1'b0));
    send_item(make_item(rse_pkg::KIND_PUSH_IMM, 31'd0, 1'b0));
    send_item(make_item(rse_pkg::KIND_DIV, 31'd0, 1'b0));
    send_item(make_item(rse_pkg::KIND_PUSH_IMM, 31'd3, 1'b0));
    send_item(make_item(KIND_SPARE_6, 31'd0, 1'b1));
    send_item(make_item(rse_pkg::KIND_MUL, 31'd0, 1'b1));
    send_item(make_item(rse_pkg::KIND_PUSH_IMM, 31'd7, 1'b0));
    send_item(make_item(KIND_SPARE_7, 31'h7FFF_FFFF, 1'b1));
    send_item(make_item(rse_pkg::KIND_PUSH_IMM, 31'd2, 1'b0));
    send_item(make_item(rse_pkg::KIND_PUSH_IMM, 31'd1, 1'b1));
    send_item(make_item(rse_pkg::KIND_PUSH_IMM, 31'd0, 1'b0));
    send_item(make_item(rse_pkg::KIND_PUSH_IMM, 31'd7, 1'b0));
    send_item(make_item(rse_pkg::KIND_SUB, 31'd0, 1'b0));
    send_item(make_item(rse_pkg::KIND_PUSH_IMM, 31'd2, 1'b0));
    send_item(make_item(rse_pkg::KIND_DIV, 31'd0, 1'b1));
    send_item(make_item(KIND_SPARE_6, 31'd0, 1'b1));
    finish_phase();

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       xv = 32'h7FFF_FFFF;
        1:       xv = 32'h0000_0000;
        2:       xv = 32'hFFFF_FFFF;
        3:       xv = 32'h8000_0000;
        default: xv = $urandom;
      endcase
      write_x(xv);
      idle_on = (phase != 2);
      if (phase == 4) hold_req <= 1'b1;
      budget = items_sent + PHASE_ITEMS;
      while (items_sent < budget) begin
        sel = $urandom_range(99);
        if (sel < 68) begin
          run_wellformed();
        end else if (sel < 74) begin
          run_deep();
        end else begin
          run_noise();
        end
      end
      finish_phase();
    end

    if (shadow.pending() != 0)
      shadow.report_mismatch($sformatf("%0d results never arrived", shadow.pending()));
    if (shadow.fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/rse_pkg.sv
hdl/rpn_stack_evaluator.sv
hdl/rse_checker.sv
tb/tb.sv
